// ===== hdl/aeskx_pkg.sv =====
package aeskx_pkg;

	typedef struct packed {
		logic [3:0]  round_index;
		logic [31:0] key_word0;
		logic [31:0] key_word1;
		logic [31:0] key_word2;
		logic [31:0] key_word3;
	} aeskx_in_t;

	typedef struct packed {
		logic [31:0] next_word0;
		logic [31:0] next_word1;
		logic [31:0] next_word2;
		logic [31:0] next_word3;
	} aeskx_out_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [16] = '{
		8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
		8'h80, 8'h1B, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

endpackage

// ===== hdl/aeskx_sbox_lane.sv =====
module aeskx_sbox_lane import aeskx_pkg::*; (
	input  logic [7:0] din,
	output logic [7:0] dout
);

	assign dout = SBOX[din];

endmodule

// ===== hdl/aeskx_merge.sv =====
module aeskx_merge import aeskx_pkg::*; (
	input  logic [31:0] sub_word,
	input  logic [7:0]  rcon,
	input  logic [31:0] w0,
	input  logic [31:0] w1,
	input  logic [31:0] w2,
	input  logic [31:0] w3,
	output aeskx_out_t  result
);

	logic [31:0] n0, n1, n2;

	assign n0 = w0 ^ sub_word ^ {rcon, 24'h0};
	assign n1 = w1 ^ n0;
	assign n2 = w2 ^ n1;
	assign result = '{next_word0: n0, next_word1: n1, next_word2: n2, next_word3: w3 ^ n2};

endmodule

// ===== hdl/aes128_key_expansion_round.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | aeskx_in_t
// out     | output    | out_valid/out_stall | aeskx_out_t
//
// S-box lanes register in stage 1, the word chain in stage 2. One
// request per cycle in steady state while out is not stalled.
// arst_n clears the valid bits only. A stall on out holds stage 2
// when full, and stage 1 only when both are full, raising in_stall.
module aes128_key_expansion_round import aeskx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  aeskx_in_t  in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output aeskx_out_t out_data
);

	logic [31:0] rot, sub;
	logic [31:0] sub_s1, w0_s1, w1_s1, w2_s1, w3_s1;
	logic [7:0]  rcon_s1;
	logic        vld_s1, vld_s2;
	logic        adv_s2, adv_s1;
	aeskx_out_t  merged, res_s2;

	assign rot = {in_data.key_word3[23:0], in_data.key_word3[31:24]};

	for (genvar i = 0; i < 4; i++) begin : g_lane
		aeskx_sbox_lane u_lane (.din(rot[8*i +: 8]), .dout(sub[8*i +: 8]));
	end

	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			sub_s1  <= sub;
			rcon_s1 <= RCON[in_data.round_index];
			w0_s1   <= in_data.key_word0;
			w1_s1   <= in_data.key_word1;
			w2_s1   <= in_data.key_word2;
			w3_s1   <= in_data.key_word3;
		end
		if (adv_s2 && vld_s1) res_s2 <= merged;
	end

	aeskx_merge u_merge (
		.sub_word(sub_s1), .rcon(rcon_s1),
		.w0(w0_s1), .w1(w1_s1), .w2(w2_s1), .w3(w3_s1),
		.result(merged)
	);

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

endmodule

// ===== bench/tb_aes128_key_expansion_round.sv =====
`timescale 1ns / 1ps

module tb_aes128_key_expansion_round;
	import aeskx_pkg::*;

	localparam int RANDOM_REQUESTS = 1900;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 8;

	class key_schedule_board;
		aeskx_out_t next_keys[$];

		function aeskx_out_t next_round_key(aeskx_in_t r);
			aeskx_out_t k;
			logic [31:0] rot;
			logic [31:0] temp;
			rot  = {r.key_word3[23:0], r.key_word3[31:24]};
			temp = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
			temp ^= {RCON[r.round_index], 24'h0};
			k.next_word0 = r.key_word0 ^ temp;
			k.next_word1 = r.key_word1 ^ k.next_word0;
			k.next_word2 = r.key_word2 ^ k.next_word1;
			k.next_word3 = r.key_word3 ^ k.next_word2;
			return k;
		endfunction

		function void note_request(aeskx_in_t r);
			next_keys.push_back(next_round_key(r));
		endfunction

		// Returns an empty string when the result matches the oldest key held.
		function string check_result(aeskx_out_t got);
			aeskx_out_t want;
			string msg;
			if (next_keys.size() == 0)
				return $sformatf("unexpected result %h", got);
			want = next_keys.pop_front();
			msg = "";
			if (got.next_word0 !== want.next_word0)
				msg = {msg, $sformatf(" word0 %h/%h", got.next_word0, want.next_word0)};
			if (got.next_word1 !== want.next_word1)
				msg = {msg, $sformatf(" word1 %h/%h", got.next_word1, want.next_word1)};
			if (got.next_word2 !== want.next_word2)
				msg = {msg, $sformatf(" word2 %h/%h", got.next_word2, want.next_word2)};
			if (got.next_word3 !== want.next_word3)
				msg = {msg, $sformatf(" word3 %h/%h", got.next_word3, want.next_word3)};
			return msg;
		endfunction

		function int pending();
			return next_keys.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	aeskx_in_t  in_data;
	logic       out_valid;
	logic       out_stall;
	aeskx_out_t out_data;

	key_schedule_board board;
	int  fail_count;
	int  cycle_count;
	bit  quiet;

	aes128_key_expansion_round u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch at cycle %0d:%s", cycle_count, msg);
	endtask

	// Monitor both handshakes at the rising edge.
	always @(posedge clk) begin
		string msg;
		cycle_count++;
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_request(in_data);
			if (out_valid && !out_stall) begin
				msg = board.check_result(out_data);
				if (msg != "")
					report_mismatch(msg);
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_aes128_key_expansion_round: FAIL");
			$finish;
		end
	end

	// Receiver: stall in bursts, run clear once quiet.
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				n = quiet ? 1 : $urandom_range(1, 20);
			end else begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 14);
			end
			repeat (n) @(negedge clk);
		end
	end

	task automatic send_request(aeskx_in_t r);
		int gap;
		@(negedge clk);
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic aeskx_in_t random_request();
		aeskx_in_t r;
		r.round_index = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 10));
		r.key_word0 = $urandom;
		r.key_word1 = $urandom;
		r.key_word2 = $urandom;
		r.key_word3 = $urandom;
		return r;
	endfunction

	task automatic wait_drained();
		while (board.pending() != 0) @(posedge clk);
	endtask

	initial begin
		aeskx_in_t r;
		int drain;
		board = new();
		fail_count = 0;
		cycle_count = 0;
		quiet = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every round index, in range and out of it, on the standard cipher key.
		for (int i = 0; i < 16; i++) begin
			r = {4'(i), 32'h2b7e1516, 32'h28aed2a6, 32'habf71588, 32'h09cf4f3c};
			send_request(r);
		end
		send_request({4'd1, 32'h0, 32'h0, 32'h0, 32'h0});
		send_request({4'd10, {4{32'hffffffff}}});
		send_request({4'd8, 32'h0, 32'h0, 32'h0, 32'hffffffff});
		send_request({4'd15, {4{32'h5a5aa5a5}}});
		send_request({4'd0, 32'hffffffff, 32'h0, 32'hffffffff, 32'h0});

		// Hold off until the pipeline has emptied.
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS - 300)
				quiet = 1'b1;
			send_request(random_request());
		end
		@(negedge clk);
		in_valid <= 1'b0;

		wait_drained();
		drain = 0;
		while (drain < DRAIN_CYCLES) begin
			@(posedge clk);
			drain++;
		end
		if (fail_count == 0 && board.pending() == 0)
			$display("tb_aes128_key_expansion_round: PASS");
		else
			$display("tb_aes128_key_expansion_round: FAIL");
		$finish;
	end

endmodule
